>>> hw/rtl/rnp_pkg.sv
// types, constants and helper functions for the roman numeral parser
package rnp_pkg;

  localparam int unsigned SymCount = 13;
  localparam int unsigned SymIdxW  = $clog2(SymCount);
  localparam logic [11:0] MAX_VALUE = 12'd3999;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  localparam logic [1:0] ROLE_NINE = 2'd0;
  localparam logic [1:0] ROLE_FIVE = 2'd1;
  localparam logic [1:0] ROLE_FOUR = 2'd2;
  localparam logic [1:0] ROLE_ONE  = 2'd3;

  localparam logic [7:0] SYM_FIRST [SymCount] = '{
    8'h4d, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4c,
    8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
  };
  localparam logic [7:0] SYM_SECOND [SymCount] = '{
    8'h00, 8'h4d, 8'h00, 8'h44, 8'h00, 8'h43, 8'h00,
    8'h4c, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00
  };
  localparam logic [9:0] SYM_VALUE [SymCount] = '{
    10'd1000, 10'd900, 10'd500, 10'd400, 10'd100, 10'd90, 10'd50,
    10'd40, 10'd10, 10'd9, 10'd5, 10'd4, 10'd1
  };
  localparam logic [1:0] SYM_DECADE [SymCount] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3
  };
  localparam logic [1:0] SYM_ROLE [SymCount] = '{
    ROLE_ONE,
    ROLE_NINE, ROLE_FIVE, ROLE_FOUR, ROLE_ONE,
    ROLE_NINE, ROLE_FIVE, ROLE_FOUR, ROLE_ONE,
    ROLE_NINE, ROLE_FIVE, ROLE_FOUR, ROLE_ONE
  };

  typedef struct packed {
    logic [SymIdxW-1:0] pos;
    logic [7:0]         held_char;
    logic               held_valid;
    logic [11:0]        sum;
    logic               ovf;
    logic               stuck;
    logic               noncanon;
    logic [2:0]         rep;
  } parse_st_t;

  typedef struct packed {
    logic               hit;
    logic               pair;
    logic [SymIdxW-1:0] idx;
  } match_t;

  // first table symbol at or after pos that matches
  function automatic match_t sym_match(logic [SymIdxW-1:0] pos, logic [7:0] h,
                                       logic has_next, logic [7:0] n);
    match_t m;
    m = '0;
    for (int p = 0; p < SymCount; p++) begin
      if (!m.hit && SymIdxW'(p) >= pos) begin
        if (SYM_SECOND[p] != 8'h00) begin
          if (has_next && h == SYM_FIRST[p] && n == SYM_SECOND[p]) begin
            m.hit  = 1'b1;
            m.pair = 1'b1;
            m.idx  = SymIdxW'(p);
          end
        end else if (h == SYM_FIRST[p]) begin
          m.hit  = 1'b1;
          m.pair = 1'b0;
          m.idx  = SymIdxW'(p);
        end
      end
    end
    return m;
  endfunction

  function automatic parse_st_t sym_consume(parse_st_t st, logic [SymIdxW-1:0] s);
    parse_st_t r;
    logic [12:0] tot;
    r = st;
    if (st.rep != 3'd0) begin
      if (s == st.pos) begin
        if (SYM_ROLE[s] != ROLE_ONE) r.noncanon = 1'b1;
        if (st.rep < 3'd7) r.rep = st.rep + 3'd1;
        if (s != '0 && r.rep > 3'd3) r.noncanon = 1'b1;
      end else begin
        r.rep = 3'd1;
        if (SYM_DECADE[s] == SYM_DECADE[st.pos] &&
            !(SYM_ROLE[st.pos] == ROLE_FIVE && SYM_ROLE[s] == ROLE_ONE)) begin
          r.noncanon = 1'b1;
        end
      end
    end else begin
      r.rep = 3'd1;
    end
    r.pos = s;
    tot = {1'b0, st.sum} + {3'b000, SYM_VALUE[s]};
    if (tot > {1'b0, MAX_VALUE}) begin
      r.ovf = 1'b1;
      r.sum = MAX_VALUE;
    end else begin
      r.sum = tot[11:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/roman_numeral_parser.sv
// roman numeral parser top level: character stage, parse state and result register
//
// input channel: one character per transfer on in_char_code, in_last set on
// the final character of a numeral. lower case letters are folded to upper.
// result channel: one transfer per numeral carrying out_value and out_status
// (ok, invalid, out of range); out_value is zero unless the status is ok.
// both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// throughput: one character per cycle unless the character stage stalls, set
// by the combinational parse step (priority match against the symbol table
// plus the saturating add). the last character of a numeral is captured in
// the character stage, which resolves it into the result register once that
// register is free.
// when the receiver stalls, the result register holds; the character stage
// keeps taking characters that produce no result and stalls only a last
// character that finds the result register still full.
// reset (rst_n low, synchronous) empties both stages and clears the parse
// state, so the next character starts a new numeral.
module roman_numeral_parser
  import rnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_value,
  output logic [1:0]  out_status
);

  logic        stg_valid_r;
  logic [7:0]  stg_char_r;
  logic        stg_last_r;
  parse_st_t   st_r;
  parse_st_t   st_nxt;
  logic        out_valid_r;
  logic [11:0] out_value_r;
  status_t     out_status_r;

  logic        out_free;
  logic        adv;
  logic [7:0]  c;
  match_t      m1;
  match_t      m2;
  parse_st_t   s1;
  parse_st_t   s2;
  status_t     res_status;
  logic [11:0] res_value;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = stg_valid_r && (!stg_last_r || out_free);
  assign in_stall = stg_valid_r && !adv;

  always_comb begin
    c = stg_char_r;
    if (stg_char_r >= 8'h61 && stg_char_r <= 8'h7a) c = stg_char_r - 8'h20;

    // resolve the held character against the incoming one
    s1 = st_r;
    m1 = sym_match(st_r.pos, st_r.held_char, 1'b1, c);
    if (!st_r.stuck) begin
      if (st_r.held_valid) begin
        if (m1.hit) begin
          s1 = sym_consume(st_r, m1.idx);
          if (m1.pair) s1.held_valid = 1'b0;
          else         s1.held_char  = c;
        end else begin
          s1.stuck = 1'b1;
        end
      end else begin
        s1.held_char  = c;
        s1.held_valid = 1'b1;
      end
    end

    // on the last character, flush the held one with no neighbour
    s2 = s1;
    m2 = sym_match(s1.pos, s1.held_char, 1'b0, 8'h00);
    if (!s1.stuck && s1.held_valid) begin
      if (m2.hit) s2 = sym_consume(s1, m2.idx);
      else        s2.stuck = 1'b1;
    end

    res_value = 12'd0;
    if (s2.stuck) begin
      res_status = ST_INVALID;
    end else if (s2.ovf) begin
      res_status = ST_RANGE;
    end else if (s2.noncanon) begin
      res_status = ST_INVALID;
    end else begin
      res_status = ST_OK;
      res_value  = s2.sum;
    end

    st_nxt = st_r;
    if (adv) begin
      if (stg_last_r) st_nxt = '0;
      else            st_nxt = s1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (!stg_valid_r || adv) stg_valid_r <= in_valid;
      if (adv && stg_last_r) out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_char_r <= in_char_code;
      stg_last_r <= in_last;
    end
    if (adv && stg_last_r) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
